// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

   // Command codes carried by req_command.
   typedef enum logic [2:0] {
      CMD_PUT       = 3'd0,
      CMD_COLOR_PUT = 3'd1,
      CMD_CLEAR     = 3'd2,
      CMD_FILL      = 3'd3,
      CMD_BACKSPACE = 3'd4,
      CMD_LEFT      = 3'd5,
      CMD_RIGHT     = 3'd6,
      CMD_READ      = 3'd7
   } cmd_type;

   // Character and attribute bytes with a meaning of their own.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_PROMPT  = 8'h3E;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] ATTR_RESET = 8'h07;

   // Write enables from the sequencer to the two stores.
   typedef struct packed {
      logic char_we;
      logic attr_we;
   } tcw_wr_en_type;

endpackage

`default_nettype wire

// ===== rtl/tcw_stores.sv =====
`default_nettype none

module tcw_stores import tcw_pkg::*; #(
   parameter int unsigned DEPTH  = 2000,
   parameter int unsigned ADDR_W = 11
) (
   input  wire logic                clock,
   input  wire tcw_wr_en_type       wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [7:0]          wr_char,
   input  wire logic [7:0]          wr_attr,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [7:0]          rd_char,
   output logic      [7:0]          rd_attr
);

   logic [7:0] char_mem_ff [DEPTH];
   logic [7:0] attr_mem_ff [DEPTH];
   logic [7:0] rd_char_ff;
   logic [7:0] rd_attr_ff;

   // Character store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en.char_we) begin
         char_mem_ff[wr_addr] <= wr_char;
      end
      rd_char_ff <= char_mem_ff[rd_addr];
   end

   // Attribute store: same organization.
   always_ff @(posedge clock) begin
      if (wr_en.attr_we) begin
         attr_mem_ff[wr_addr] <= wr_attr;
      end
      rd_attr_ff <= attr_mem_ff[rd_addr];
   end

   assign rd_char = rd_char_ff;
   assign rd_attr = rd_attr_ff;

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Text console writer: a COLUMNS x ROWS character console with a character
// store, an attribute store and a linear cursor. One command item is taken at
// a time and returns one result item with the cursor position; a read also
// returns the cell's character and attribute. After reset the block writes
// spaces and attribute 0x07 into every cell of both stores, and holds
// req_stall high meanwhile. Each store allows one write and one read per
// cycle. A put writes at the cursor, and a newline only moves it; left,
// backspace and read first read one cell, and right scans from the cursor to
// the first non-space cell. Right ends at once on a full screen, left and
// backspace at cursor 0, and a read of a cell out of range returns zeros.
// Clear and fill walk every cell, and a put on a full screen scrolls first.
// The input opens again as the result is loaded. A finished result sits in
// an output register; while it is stalled the next item still runs, and only
// that item's result waits for the register to empty.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [7:0]  req_color,
   input  wire logic [10:0] req_cell_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [10:0] rsp_cursor_pos,
   output logic      [7:0]  rsp_cell_char,
   output logic      [7:0]  rsp_cell_color
);

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned CW    = $clog2(CELLS + 1);
   localparam int unsigned AW    = $clog2(CELLS);
   localparam int unsigned COLW  = $clog2(COLUMNS);
   localparam int unsigned IXW   = (CW > 11) ? CW : 11;

   localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
   localparam logic [CW-1:0]   LAST_C     = CW'(CELLS - 1);
   localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   COLS_C     = CW'(COLUMNS);
   localparam logic [COLW-1:0] COL_LAST_C = COLW'(COLUMNS - 1);
   localparam logic [IXW-1:0]  CELLS_IX_C = IXW'(CELLS);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_BLANK,
      ST_PUT,
      ST_WALK,
      ST_BACK_RD,
      ST_BACK_CHK,
      ST_SCAN,
      ST_READ,
      ST_READ_CAP,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [7:0]       char_ff, char_in;
   logic [7:0]       color_ff, color_in;
   logic [10:0]      idx_ff, idx_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [COLW-1:0]  col_ff, col_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    wptr_ff, wptr_in;
   logic             pend_ff, pend_in;
   logic [7:0]       res_char_ff, res_char_in;
   logic [7:0]       res_color_ff, res_color_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [10:0]      rsp_cursor_ff, rsp_cursor_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [7:0]       rsp_color_ff, rsp_color_in;

   tcw_wr_en_type    wr_en;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_char;
   logic [7:0]       wr_attr;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_char;
   logic [7:0]       rd_attr;

   logic [CW-1:0]    cursor_dec;
   logic [COLW-1:0]  col_inc;
   logic [COLW-1:0]  col_dec;
   logic [IXW-1:0]   idx_ext;
   logic [IXW-1:0]   cursor_ext;
   logic             issue;

   // Both stores live behind one write port and one read port each.
   tcw_stores #(
      .DEPTH  (CELLS),
      .ADDR_W (AW)
   ) u_stores (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_char (wr_char),
      .wr_attr (wr_attr),
      .rd_addr (rd_addr),
      .rd_char (rd_char),
      .rd_attr (rd_attr)
   );

   // Cursor and column neighbors, kept apart so no division is needed.
   assign cursor_dec = cursor_ff - CW'(1);
   assign col_inc    = (col_ff == COL_LAST_C) ? '0 : col_ff + COLW'(1);
   assign col_dec    = (col_ff == '0) ? COL_LAST_C : col_ff - COLW'(1);
   assign idx_ext    = IXW'(idx_ff);
   assign cursor_ext = IXW'(cursor_ff);
   assign issue      = (ptr_ff < CELLS_C);

   // Sequencer: walks the stores with the pointers and updates the cursor.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      char_in       = char_ff;
      color_in      = color_ff;
      idx_in        = idx_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      ptr_in        = ptr_ff;
      wptr_in       = wptr_ff;
      pend_in       = pend_ff;
      res_char_in   = res_char_ff;
      res_color_in  = res_color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_color_in  = rsp_color_ff;
      wr_en         = '0;
      wr_addr       = wptr_ff[AW-1:0];
      wr_char       = CH_SPACE;
      wr_attr       = color_ff;
      rd_addr       = ptr_ff[AW-1:0];

      // The output register empties when its item is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            wr_en.char_we = 1'b1;
            wr_en.attr_we = 1'b1;
            wr_attr       = ATTR_RESET;
            wptr_in       = wptr_ff + CW'(1);
            if (wptr_ff == LAST_C) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = cmd_type'(req_command);
               char_in      = req_char_code;
               color_in     = req_color;
               idx_in       = req_cell_index;
               res_char_in  = '0;
               res_color_in = '0;
               pend_in      = 1'b0;
               case (cmd_type'(req_command))
                  CMD_PUT, CMD_COLOR_PUT: begin
                     if (cursor_ff == CELLS_C) begin
                        ptr_in   = COLS_C;
                        wptr_in  = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  CMD_CLEAR, CMD_FILL: begin
                     wptr_in  = '0;
                     state_in = ST_WALK;
                  end
                  CMD_BACKSPACE, CMD_LEFT: begin
                     state_in = (cursor_ff == '0) ? ST_RESP : ST_BACK_RD;
                  end
                  CMD_RIGHT: begin
                     ptr_in   = cursor_ff;
                     state_in = ST_SCAN;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // Read one row ahead and write each character back in the next cycle.
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            pend_in = issue;
            if (pend_ff) begin
               wr_en.char_we = 1'b1;
               wr_char       = rd_char;
               wptr_in       = wptr_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            wr_en.char_we = 1'b1;
            wptr_in       = wptr_ff + CW'(1);
            if (wptr_ff == LAST_C) begin
               cursor_in = LAST_ROW_C;
               col_in    = '0;
               state_in  = ST_PUT;
            end
         end
         ST_PUT: begin
            if (char_ff == CH_NEWLINE) begin
               cursor_in = cursor_ff + COLS_C - CW'(col_ff);
               col_in    = '0;
            end else begin
               wr_en.char_we = 1'b1;
               wr_en.attr_we = (cmd_ff == CMD_COLOR_PUT);
               wr_addr       = cursor_ff[AW-1:0];
               wr_char       = char_ff;
               cursor_in     = cursor_ff + CW'(1);
               col_in        = col_inc;
            end
            state_in = ST_RESP;
         end
         ST_WALK: begin
            if (cmd_ff == CMD_CLEAR) begin
               wr_en.char_we = 1'b1;
            end else begin
               wr_en.attr_we = 1'b1;
            end
            wptr_in = wptr_ff + CW'(1);
            if (wptr_ff == LAST_C) begin
               if (cmd_ff == CMD_CLEAR) begin
                  cursor_in = '0;
                  col_in    = '0;
               end
               state_in = ST_RESP;
            end
         end
         ST_BACK_RD: begin
            rd_addr  = cursor_dec[AW-1:0];
            state_in = ST_BACK_CHK;
         end
         ST_BACK_CHK: begin
            if (rd_char != CH_PROMPT && rd_char != CH_BSLASH) begin
               if (cmd_ff == CMD_BACKSPACE) begin
                  wr_en.char_we = 1'b1;
                  wr_addr       = cursor_dec[AW-1:0];
               end
               cursor_in = cursor_dec;
               col_in    = col_dec;
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // Stream reads from the cursor on; stop at the first non-space.
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            pend_in = issue;
            if (pend_ff && rd_char != CH_SPACE) begin
               cursor_in = cursor_ff + CW'(1);
               col_in    = col_inc;
               pend_in   = 1'b0;
               state_in  = ST_RESP;
            end else if (!issue && !pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            rd_addr = idx_ext[AW-1:0];
            if (idx_ext < CELLS_IX_C) begin
               state_in = ST_READ_CAP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ_CAP: begin
            res_char_in  = rd_char;
            res_color_in = rd_attr;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = cursor_ext[10:0];
               rsp_char_in   = res_char_ff;
               rsp_color_in  = res_color_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, datapath and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         col_ff       <= '0;
         wptr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         wptr_ff      <= wptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      char_ff       <= char_in;
      color_ff      <= color_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      res_char_ff   <= res_char_in;
      res_color_ff  <= res_color_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_color = rsp_color_ff;

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`default_nettype none

module tcw_checker #(
   parameter int unsigned CELLS = 2000
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [10:0] rsp_cursor_pos,
   input wire logic [7:0]  rsp_cell_char,
   input wire logic [7:0]  rsp_cell_color
);

   // Reset starts the store clearing pass with no item pending.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_stall))
      else $error("item pending or input open right after reset");

   // One item at a time: an accepted item closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input still open after an item was accepted");

   // The cursor never passes the full-screen position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CELLS > 2047) || (32'(rsp_cursor_pos) <= CELLS)))
      else $error("cursor beyond the full-screen position");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_cell_char) && $stable(rsp_cell_color)))
      else $error("stalled result changed or dropped");

endmodule

bind text_console_writer tcw_checker #(.CELLS(COLUMNS * ROWS)) u_tcw_checker (.*);

`default_nettype wire

// ===== bench/text_console_writer_tb.sv =====
`default_nettype none

module text_console_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int unsigned COLUMNS       = 80;
   localparam int unsigned ROWS          = 25;
   localparam int unsigned CELLS         = COLUMNS * ROWS;
   localparam int unsigned MAX_GAP       = 18;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned SETTLE_CYCLES = CELLS + 100;
   localparam int unsigned RANDOM_ITEMS  = 215;
   localparam int unsigned MAX_REPORTS   = 200;
   // Worst case is about 330 items; the limit allows four times their run time.
   localparam longint unsigned RUN_LIMIT_NS = 64'd12_000_000;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_color;
   } console_result_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command    = CMD_READ;
   logic [7:0]  req_char_code  = 8'h00;
   logic [7:0]  req_color      = 8'h00;
   logic [10:0] req_cell_index = 11'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [10:0] rsp_cursor_pos;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_color;

   // Shadow copy of the console contents and cursor.
   logic [7:0]  screen_chars [CELLS];
   logic [7:0]  screen_attrs [CELLS];
   int unsigned cursor_shadow;

   console_result_type pending_results [$];

   bit          req_gaps_on  = 1'b0;
   bit          rsp_gaps_on  = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned failures        = 0;
   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned scroll_count    = 0;
   int unsigned read_count      = 0;

   always #2 clock = ~clock;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_char_code (req_char_code),
      .req_color     (req_color),
      .req_cell_index(req_cell_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cell_color(rsp_cell_color)
   );

   function automatic int unsigned draw_gap(input bit enabled);
      return enabled ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   // Applies one command to the shadow console and returns the cursor and cell it reports.
   function automatic console_result_type console_apply(input cmd_type cmd,
                                                        input logic [7:0] ch,
                                                        input logic [7:0] col,
                                                        input logic [10:0] idx);
      console_result_type r;
      int unsigned i;
      bit found;
      r.cell_char  = 8'h00;
      r.cell_color = 8'h00;
      found        = 1'b0;
      case (cmd)
         CMD_PUT, CMD_COLOR_PUT: begin
            // A full screen scrolls the characters up one row before the put.
            if (cursor_shadow >= CELLS) begin
               for (i = COLUMNS; i < CELLS; i++) begin
                  screen_chars[i - COLUMNS] = screen_chars[i];
               end
               for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                  screen_chars[i] = CH_SPACE;
               end
               cursor_shadow = CELLS - COLUMNS;
               scroll_count++;
            end
            if (ch == CH_NEWLINE) begin
               cursor_shadow = cursor_shadow + COLUMNS - (cursor_shadow % COLUMNS);
            end else begin
               screen_chars[cursor_shadow] = ch;
               if (cmd == CMD_COLOR_PUT) begin
                  screen_attrs[cursor_shadow] = col;
               end
               cursor_shadow++;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CELLS; i++) begin
               screen_chars[i] = CH_SPACE;
            end
            cursor_shadow = 0;
         end
         CMD_FILL: begin
            for (i = 0; i < CELLS; i++) begin
               screen_attrs[i] = col;
            end
         end
         CMD_BACKSPACE, CMD_LEFT: begin
            // Moving back stops at the origin and at a prompt or backslash.
            if (cursor_shadow != 0 && cursor_shadow <= CELLS &&
                screen_chars[cursor_shadow - 1] != CH_PROMPT &&
                screen_chars[cursor_shadow - 1] != CH_BSLASH) begin
               if (cmd == CMD_BACKSPACE) begin
                  screen_chars[cursor_shadow - 1] = CH_SPACE;
               end
               cursor_shadow--;
            end
         end
         CMD_RIGHT: begin
            for (i = cursor_shadow; i < CELLS; i++) begin
               if (screen_chars[i] != CH_SPACE) begin
                  found = 1'b1;
               end
            end
            if (found) begin
               cursor_shadow++;
            end
         end
         default: begin
            read_count++;
            if (idx < CELLS) begin
               r.cell_char  = screen_chars[idx];
               r.cell_color = screen_attrs[idx];
            end
         end
      endcase
      r.cursor_pos = cursor_shadow[10:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      // Keep the log readable when something is badly broken.
      if (failures <= MAX_REPORTS) begin
         $display("MISMATCH at %0t ns: %s", $realtime, what);
      end
   endtask

   // Offers one command item and records its expected result once it is taken.
   task automatic send_command(input cmd_type cmd, input logic [7:0] ch,
                               input logic [7:0] col, input logic [10:0] idx);
      int unsigned gap;
      gap = draw_gap(req_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_char_code  <= ch;
      req_color      <= col;
      req_cell_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(console_apply(cmd, ch, col, idx));
      items_sent++;
   endtask

   // Stops offering and waits until every expected result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Reads of the reset contents, including cells past the end of the screen.
   task automatic test_reset_contents();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_command(CMD_READ, 8'h00, 8'h00, 11'd0);
      send_command(CMD_READ, 8'hFF, 8'hFF, 11'(CELLS - 1));
      send_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS));
      send_command(CMD_READ, 8'h00, 8'h00, 11'h7FF);
   endtask

   // Every command at least once, prompt and backslash guards, and moves at the origin.
   task automatic test_directed_edits();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_command(CMD_PUT, 8'h41, 8'hFF, 11'd0);
      send_command(CMD_COLOR_PUT, 8'hFF, 8'h00, 11'd0);
      send_command(CMD_COLOR_PUT, 8'h00, 8'hFF, 11'h7FF);
      send_command(CMD_PUT, CH_PROMPT, 8'h00, 11'd0);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_LEFT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, CH_BSLASH, 8'h00, 11'd0);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, 8'h71, 8'h00, 11'd0);
      send_command(CMD_LEFT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_RIGHT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_RIGHT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, 8'h7A, 8'h00, 11'd0);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_READ, 8'h00, 8'h00, 11'd1);
      send_command(CMD_FILL, 8'h00, 8'hFF, 11'd0);
      send_command(CMD_READ, 8'h00, 8'h00, 11'd2);
      send_command(CMD_COLOR_PUT, CH_NEWLINE, 8'h5A, 11'd0);
      send_command(CMD_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_LEFT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_RIGHT, 8'h00, 8'h00, 11'd0);
   endtask

   // Fills the screen with newlines, edits at the full position and scrolls twice.
   task automatic test_full_screen();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      send_command(CMD_CLEAR, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, 8'h54, 8'h00, 11'd0);
      repeat (ROWS - 1) send_command(CMD_PUT, CH_NEWLINE, 8'h00, 11'd0);
      send_command(CMD_COLOR_PUT, 8'h4C, 8'hC3, 11'd0);
      send_command(CMD_PUT, CH_NEWLINE, 8'h00, 11'd0);
      send_command(CMD_RIGHT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_LEFT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_RIGHT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, 8'h52, 8'h00, 11'd0);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, CH_PROMPT, 8'h00, 11'd0);
      send_command(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
      send_command(CMD_LEFT, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, 8'h53, 8'h00, 11'd0);
      send_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS - 2 * COLUMNS));
      send_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS - COLUMNS - 1));
      send_command(CMD_READ, 8'h00, 8'h00, 11'd0);
      send_command(CMD_PUT, CH_NEWLINE, 8'h00, 11'd0);
      send_command(CMD_PUT, CH_NEWLINE, 8'h00, 11'd0);
      send_command(CMD_READ, 8'h00, 8'h00, 11'(CELLS - 1));
   endtask

   // The receiver holds off for a long stretch while puts keep coming.
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = 1'b1;
      repeat (16) begin
         send_command(CMD_PUT, 8'($urandom_range(8'h21, 8'h7E)), 8'h00, 11'd0);
      end
   endtask

   // Mostly typed lines and edits with random content, plus reads and some noise.
   task automatic test_random_session(input int unsigned target);
      int unsigned first;
      int unsigned len;
      int unsigned k;
      logic [7:0]  ch;
      logic [10:0] idx;
      cmd_type     cmd;
      first = items_sent;
      while (items_sent - first < target) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               len = $urandom_range(0, 10);
               for (k = 0; k < len; k++) begin
                  case ($urandom_range(0, 9))
                     0: ch = CH_SPACE;
                     1: ch = 8'($urandom_range(0, 255));
                     default: ch = 8'($urandom_range(8'h21, 8'h7E));
                  endcase
                  cmd = ($urandom_range(0, 1) != 0) ? CMD_COLOR_PUT : CMD_PUT;
                  send_command(cmd, ch, 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047)));
               end
               if ($urandom_range(0, 9) != 0) begin
                  send_command(CMD_PUT, CH_NEWLINE, 8'($urandom_range(0, 255)), 11'd0);
               end
            end
            6: begin
               ch = ($urandom_range(0, 1) != 0) ? CH_PROMPT : CH_BSLASH;
               send_command(CMD_PUT, ch, 8'h00, 11'd0);
               len = $urandom_range(0, 6);
               for (k = 0; k < len; k++) begin
                  send_command(CMD_PUT, 8'($urandom_range(8'h21, 8'h7E)), 8'h00, 11'd0);
               end
               len = $urandom_range(1, 8);
               for (k = 0; k < len; k++) begin
                  cmd = cmd_type'(3'($urandom_range(CMD_BACKSPACE, CMD_RIGHT)));
                  send_command(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047)));
               end
               if ($urandom_range(0, 1) != 0) begin
                  send_command(CMD_PUT, CH_NEWLINE, 8'h00, 11'd0);
               end
            end
            7: begin
               repeat (3) begin
                  case ($urandom_range(0, 5))
                     0: idx = 11'($urandom_range(CELLS, 2047));
                     1, 2: idx = 11'((cursor_shadow > 0) ? cursor_shadow - 1 : 0);
                     default: idx = 11'($urandom_range(0, CELLS - 1));
                  endcase
                  send_command(CMD_READ, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), idx);
               end
            end
            8: begin
               // Clears are kept rare so that the screen gets full and scrolls.
               cmd = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_FILL;
               send_command(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, 2047)));
            end
            default: begin
               repeat ($urandom_range(1, 3)) begin
                  cmd = cmd_type'(3'($urandom_range(0, 7)));
                  if (cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) begin
                     cmd = CMD_FILL;
                  end
                  send_command(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047)));
               end
            end
         endcase
      end
   endtask

   // Result side: a random stall before each item, and one long hold on request.
   initial begin : result_receiver
      int unsigned stall_cycles;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall_cycles = draw_gap(rsp_gaps_on);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : result_checker
      console_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result item with no command waiting");
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_cursor_pos !== want.cursor_pos) begin
               report_mismatch($sformatf("cursor_pos got %0d, expected %0d",
                                         rsp_cursor_pos, want.cursor_pos));
            end
            if (rsp_cell_char !== want.cell_char) begin
               report_mismatch($sformatf("cell_char got %02h, expected %02h",
                                         rsp_cell_char, want.cell_char));
            end
            if (rsp_cell_color !== want.cell_color) begin
               report_mismatch($sformatf("cell_color got %02h, expected %02h",
                                         rsp_cell_color, want.cell_color));
            end
         end
      end
   end

   initial begin : test_sequence
      int unsigned i;
      for (i = 0; i < CELLS; i++) begin
         screen_chars[i] = CH_SPACE;
         screen_attrs[i] = ATTR_RESET;
      end
      cursor_shadow = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      wait_for_results();
      test_directed_edits();
      wait_for_results();
      test_full_screen();
      wait_for_results();
      test_backpressure();
      wait_for_results();
      test_random_session(RANDOM_ITEMS);
      wait_for_results();

      // Give a stray extra result time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d results for %0d commands, with %0d cell reads and %0d scrolls.",
               results_checked, items_sent, read_count, scroll_count);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Timeout: the run did not finish in time.");
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
